// ===== design/mta_pkg.sv =====
// ----------------------------------------------------------------------------
// mta_pkg
// Shared constants, types and register codes of the mosaic tile averager.
// ----------------------------------------------------------------------------
`default_nettype none

package mta_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MAX_TILE   = 64;

  localparam int unsigned XW         = $clog2(MAX_WIDTH);
  localparam int unsigned YW         = $clog2(MAX_HEIGHT);
  localparam int unsigned TW         = $clog2(MAX_TILE);
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned TILE_REG_W = 7;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CNT_W      = 2 * TW + 1;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned NCH        = 3;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned SUMS_W     = NCH * SUM_W;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
  localparam int unsigned REM_W      = CNT_W + 1;

  localparam logic [DIM_W-1:0]      WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0]      HEIGHT_RESET = DIM_W'(480);
  localparam logic [TILE_REG_W-1:0] TILE_RESET   = TILE_REG_W'(12);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TILE_SIZE    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [YW-1:0]                tile_row;
    logic [XW-1:0]                tile_col;
    logic [NCH-1:0][SUM_W-1:0]    sums;
    logic [CNT_W-1:0]             count;
    logic                         frame_done;
  } tile_job_t;

endpackage

`default_nettype wire

// ===== design/mta_ram.sv =====
// ----------------------------------------------------------------------------
// mta_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/mta_front.sv =====
// ----------------------------------------------------------------------------
// mta_front
// Pixel intake: tracks the raster position, accumulates the per-column sums
// in the column store and queues a job for every finished tile.
// ----------------------------------------------------------------------------
`default_nettype none

module mta_front
  import mta_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [PIX_W-1:0]      chan0_i,
  input  wire logic [PIX_W-1:0]      chan1_i,
  input  wire logic [PIX_W-1:0]      chan2_i,
  input  wire logic                  frame_start_i,
  input  wire logic [FIFO_CNT_W-1:0] fifo_count_i,
  output logic                       push_o,
  output tile_job_t                  job_o
);

  logic [DIM_W-1:0]      image_width_q, image_height_q;
  logic [TILE_REG_W-1:0] tile_size_q;

  logic [XW-1:0] pixel_x_q, pixel_x_d, tile_x_q, tile_x_d;
  logic [YW-1:0] pixel_y_q, pixel_y_d, tile_y_q, tile_y_d;
  logic [TW-1:0] x_in_tile_q, x_in_tile_d, y_in_tile_q, y_in_tile_d;

  logic [DIM_W-1:0]      w_lim, h_lim;
  logic [TILE_REG_W-1:0] t_lim;
  logic [XW-1:0]         w_last, px, tx;
  logic [YW-1:0]         h_last, py, ty;
  logic [TW-1:0]         t_last, xt, yt;
  logic [TW:0]           x_span, y_span;
  logic                  restart, last_col, last_row, accept;

  logic                  s1_valid_q, s1_first_q, s1_emit_q, s1_frame_done_q;
  logic [XW-1:0]         s1_addr_q;
  logic [YW-1:0]         s1_row_q;
  logic [CNT_W-1:0]      s1_count_q;
  logic [NCH-1:0][PIX_W-1:0] s1_pix_q;

  logic                  hit_q;
  logic [SUMS_W-1:0]     fwd_q;
  logic [SUMS_W-1:0]     rd_data, base, new_sums;
  logic [FIFO_CNT_W:0]   occupancy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WIDTH_RESET;
      image_height_q <= HEIGHT_RESET;
      tile_size_q    <= TILE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
        REG_TILE_SIZE:    tile_size_q    <= cfg_data_i[TILE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_lim = (image_width_q == '0) ? DIM_W'(1) :
            (image_width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : image_width_q;
    h_lim = (image_height_q == '0) ? DIM_W'(1) :
            (image_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : image_height_q;
    t_lim = (tile_size_q == '0) ? TILE_REG_W'(1) :
            (tile_size_q > TILE_REG_W'(MAX_TILE)) ? TILE_REG_W'(MAX_TILE) : tile_size_q;
    w_last = XW'(w_lim - DIM_W'(1));
    h_last = YW'(h_lim - DIM_W'(1));
    t_last = TW'(t_lim - TILE_REG_W'(1));

    restart = frame_start_i
            || ({1'b0, pixel_x_q} >= w_lim) || ({1'b0, pixel_y_q} >= h_lim)
            || ({1'b0, x_in_tile_q} >= t_lim) || ({1'b0, y_in_tile_q} >= t_lim);

    px = restart ? '0 : pixel_x_q;
    py = restart ? '0 : pixel_y_q;
    xt = restart ? '0 : x_in_tile_q;
    yt = restart ? '0 : y_in_tile_q;
    tx = restart ? '0 : tile_x_q;
    ty = restart ? '0 : tile_y_q;

    last_col = (xt == t_last) || (px == w_last);
    last_row = (yt == t_last) || (py == h_last);
    x_span   = {1'b0, xt} + (TW+1)'(1);
    y_span   = {1'b0, yt} + (TW+1)'(1);

    pixel_x_d   = px + XW'(1);
    pixel_y_d   = py;
    x_in_tile_d = xt + TW'(1);
    y_in_tile_d = yt;
    tile_x_d    = tx;
    tile_y_d    = ty;
    if (px == w_last) begin
      pixel_x_d   = '0;
      x_in_tile_d = '0;
      tile_x_d    = '0;
      if (py == h_last) begin
        pixel_y_d   = '0;
        y_in_tile_d = '0;
        tile_y_d    = '0;
      end else begin
        pixel_y_d = py + YW'(1);
        if (yt == t_last) begin
          y_in_tile_d = '0;
          tile_y_d    = ty + YW'(1);
        end else begin
          y_in_tile_d = yt + TW'(1);
        end
      end
    end else if (xt == t_last) begin
      x_in_tile_d = '0;
      tile_x_d    = tx + XW'(1);
    end
  end

  assign occupancy  = {1'b0, fifo_count_i} + (FIFO_CNT_W+1)'(s1_valid_q && s1_emit_q);
  assign in_ready_o = occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_x_q   <= '0;
      pixel_y_q   <= '0;
      x_in_tile_q <= '0;
      y_in_tile_q <= '0;
      tile_x_q    <= '0;
      tile_y_q    <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        pixel_x_q   <= pixel_x_d;
        pixel_y_q   <= pixel_y_d;
        x_in_tile_q <= x_in_tile_d;
        y_in_tile_q <= y_in_tile_d;
        tile_x_q    <= tile_x_d;
        tile_y_q    <= tile_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q       <= tx;
      s1_row_q        <= ty;
      s1_first_q      <= (xt == '0) && (yt == '0);
      s1_emit_q       <= last_col && last_row;
      s1_frame_done_q <= (px == w_last) && (py == h_last);
      s1_count_q      <= CNT_W'(x_span) * CNT_W'(y_span);
      s1_pix_q        <= {chan2_i, chan1_i, chan0_i};
    end
    hit_q <= s1_valid_q && (s1_addr_q == tx);
    fwd_q <= new_sums;
  end

  always_comb begin
    base = s1_first_q ? '0 : (hit_q ? fwd_q : rd_data);
    for (int c = 0; c < NCH; c++) begin
      new_sums[c*SUM_W +: SUM_W] = base[c*SUM_W +: SUM_W] + SUM_W'(s1_pix_q[c]);
    end
  end

  mta_ram #(
    .WIDTH (SUMS_W),
    .DEPTH (MAX_WIDTH)
  ) u_column_sums (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (new_sums),
    .raddr_i (tx),
    .rdata_o (rd_data)
  );

  assign push_o           = s1_valid_q && s1_emit_q;
  assign job_o.tile_row   = s1_row_q;
  assign job_o.tile_col   = s1_addr_q;
  assign job_o.sums       = new_sums;
  assign job_o.count      = s1_count_q;
  assign job_o.frame_done = s1_frame_done_q;

`ifndef SYNTHESIS
  a_job_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (s1_count_q != '0))
    else $error("tile job queued with a zero pixel count");
`endif

endmodule

`default_nettype wire

// ===== design/mta_fifo.sv =====
// ----------------------------------------------------------------------------
// mta_fifo
// Short queue of tile jobs between the pixel intake and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mta_fifo
  import mta_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire tile_job_t             data_i,
  input  wire logic                  pop_i,
  output tile_job_t                  data_o,
  output logic [FIFO_CNT_W-1:0]      count_o
);

  tile_job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   count_q;

  function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FIFO_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("tile job queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("tile job queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== design/mta_back.sv =====
// ----------------------------------------------------------------------------
// mta_back
// Tile mean unit: divides the three channel sums by the pixel count, one
// quotient bit per cycle for all channels at once, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mta_back
  import mta_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  input  wire tile_job_t        job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [YW-1:0]         tile_row_o,
  output logic [XW-1:0]         tile_col_o,
  output logic [PIX_W-1:0]      mean0_o,
  output logic [PIX_W-1:0]      mean1_o,
  output logic [PIX_W-1:0]      mean2_o,
  output logic [CNT_W-1:0]      pixel_count_o,
  output logic                  frame_done_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT
  } back_state_e;

  back_state_e               state_q;
  logic [STEP_W-1:0]         step_q;
  logic [NCH-1:0][SUM_W-1:0] dividend_q;
  logic [NCH-1:0][REM_W-1:0] rem_q, rem_d;
  logic [NCH-1:0][PIX_W-1:0] quot_q, mean_q;
  logic [NCH-1:0]            qbit;
  logic [NCH-1:0][REM_W-1:0] shifted;
  logic [CNT_W-1:0]          divisor_q, count_out_q;
  logic [YW-1:0]             row_q, row_out_q;
  logic [XW-1:0]             col_q, col_out_q;
  logic                      frame_q, frame_out_q, out_valid_q;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      shifted[c] = {rem_q[c][REM_W-2:0], dividend_q[c][SUM_W-1]};
      qbit[c]    = shifted[c] >= {1'b0, divisor_q};
      rem_d[c]   = qbit[c] ? shifted[c] - {1'b0, divisor_q} : shifted[c];
    end
  end

  assign pop_o = (state_q == ST_IDLE) && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      dividend_q  <= '0;
      rem_q       <= '0;
      quot_q      <= '0;
      divisor_q   <= '0;
      row_q       <= '0;
      col_q       <= '0;
      frame_q     <= 1'b0;
      mean_q      <= '0;
      count_out_q <= '0;
      row_out_q   <= '0;
      col_out_q   <= '0;
      frame_out_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            dividend_q <= job_i.sums;
            rem_q      <= '0;
            divisor_q  <= job_i.count;
            row_q      <= job_i.tile_row;
            col_q      <= job_i.tile_col;
            frame_q    <= job_i.frame_done;
            step_q     <= '0;
            state_q    <= ST_DIV;
          end
        end
        ST_DIV: begin
          for (int c = 0; c < NCH; c++) begin
            rem_q[c]      <= rem_d[c];
            dividend_q[c] <= {dividend_q[c][SUM_W-2:0], 1'b0};
            quot_q[c]     <= {quot_q[c][PIX_W-2:0], qbit[c]};
          end
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!out_valid_q || out_ready_i) begin
            mean_q      <= quot_q;
            count_out_q <= divisor_q;
            row_out_q   <= row_q;
            col_out_q   <= col_q;
            frame_out_q <= frame_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tile_row_o    = row_out_q;
  assign tile_col_o    = col_out_q;
  assign mean0_o       = mean_q[0];
  assign mean1_o       = mean_q[1];
  assign mean2_o       = mean_q[2];
  assign pixel_count_o = count_out_q;
  assign frame_done_o  = frame_out_q;

`ifndef SYNTHESIS
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (step_q < STEP_W'(DIV_STEPS)))
    else $error("divider step counter out of range");
  a_wait_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && out_valid_q && !out_ready_i) |=> (state_q == ST_WAIT))
    else $error("finished tile left the divider while the output was blocked");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_DIV && step_q == '0))
    else $error("tile job taken without starting a division");
`endif

endmodule

`default_nettype wire

// ===== design/mosaic_tile_average.sv =====
// A pixel that closes a tile passes the intake stage, tile queue, divider and output registers.
// Throughput: one pixel per cycle while the four-entry tile queue has room.
// Each tile occupies the divider for a load, 20 quotient steps for all three channels
// and a hand-over, which bounds the sustained tile rate.
// Reset sets the registers to 640 x 480 with 12-pixel tiles and the position to the
// top left; the column store is not cleared, as each band writes a column before reading it.
`default_nettype none

module mosaic_tile_average
  import mta_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [PIX_W-1:0]     chan0_i,
  input  wire logic [PIX_W-1:0]     chan1_i,
  input  wire logic [PIX_W-1:0]     chan2_i,
  input  wire logic                 frame_start_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [YW-1:0]             tile_row_o,
  output logic [XW-1:0]             tile_col_o,
  output logic [PIX_W-1:0]          mean0_o,
  output logic [PIX_W-1:0]          mean1_o,
  output logic [PIX_W-1:0]          mean2_o,
  output logic [CNT_W-1:0]          pixel_count_o,
  output logic                      frame_done_o
);

  tile_job_t               push_job, head_job;
  logic                    push, pop;
  logic [FIFO_CNT_W-1:0]   fifo_count;

  mta_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .chan0_i       (chan0_i),
    .chan1_i       (chan1_i),
    .chan2_i       (chan2_i),
    .frame_start_i (frame_start_i),
    .fifo_count_i  (fifo_count),
    .push_o        (push),
    .job_o         (push_job)
  );

  mta_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .count_o (fifo_count)
  );

  mta_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (fifo_count != '0),
    .job_i         (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tile_row_o    (tile_row_o),
    .tile_col_o    (tile_col_o),
    .mean0_o       (mean0_o),
    .mean1_o       (mean1_o),
    .mean2_o       (mean2_o),
    .pixel_count_o (pixel_count_o),
    .frame_done_o  (frame_done_o)
  );

endmodule

`default_nettype wire
